FILE: rtl/core/speck128_block_cipher_macros.svh
// ----------------------------------------------------------------------------
// Speck128 assertion macros
// Shared concurrent assertion wrappers for the cipher checker.
// ----------------------------------------------------------------------------
`ifndef SPECK128_BLOCK_CIPHER_MACROS_SVH
`define SPECK128_BLOCK_CIPHER_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SPECK_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assertion on the block's own clk_i / rst_ni.
`define SPECK_ASSERT(lbl, prop, msg) \
  `SPECK_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/speck_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128 package
// Types, constants and round functions shared by the cipher modules.
// ----------------------------------------------------------------------------
package speck_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned ROUNDS_DEF = 32;
  localparam int unsigned MAX_ROUNDS = 34;
  localparam int unsigned ROT_ALPHA  = 8;
  localparam int unsigned ROT_BETA   = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 1'b1;

  // Command codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  cmd;
    word_t block_y;
    word_t block_x;
  } in_t;

  typedef struct packed {
    word_t result_y;
    word_t result_x;
  } out_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } pair_t;

  typedef struct packed {
    logic  cmd;
    pair_t blk;
  } stage_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WORD_W - s));
  endfunction

  // x = ror(x,8) + y ^ k ; y = rol(y,3) ^ x
  function automatic pair_t fwd_round(input pair_t p, input word_t k);
    pair_t r;
    r.x = (rotr(p.x, ROT_ALPHA) + p.y) ^ k;
    r.y = rotl(p.y, ROT_BETA) ^ r.x;
    fwd_round = r;
  endfunction

  // y = ror(y ^ x, 3) ; x = rol((x ^ k) - y, 8)
  function automatic pair_t inv_round(input pair_t p, input word_t k);
    pair_t r;
    r.y = rotr(p.y ^ p.x, ROT_BETA);
    r.x = rotl((p.x ^ k) - r.y, ROT_ALPHA);
    inv_round = r;
  endfunction

endpackage

FILE: rtl/core/speck128_block_cipher.sv
`timescale 1ns / 1ps
// Each round is a registered stage between request accept and result valid.
// Throughput: one block per cycle when not stalled; one round per stage.
// Key schedule: after reset and after every key write, in_ready_o stays low
//   while the round keys are expanded, one per cycle.
// Reset: asynchronous, active low; keys clear to zero, pipeline empties.
// ----------------------------------------------------------------------------
// Speck128/128 block cipher
// Fully pipelined encrypt/decrypt core with a precomputed round key file.
// ----------------------------------------------------------------------------
module speck128_block_cipher #(
  parameter int unsigned ROUNDS = speck_pkg::ROUNDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [speck_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  speck_pkg::word_t                cfg_data_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  speck_pkg::in_t                  in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output speck_pkg::out_t                 out_data_o
);

  // Round keys, rk[0] is key_word0 itself
  logic [ROUNDS-1:0][speck_pkg::WORD_W-1:0] rk;
  logic ks_busy;

  // Stage links: index 0 is the accepted request, index ROUNDS the last stage
  logic              stg_valid [ROUNDS+1];
  speck_pkg::stage_t stg_data  [ROUNDS+1];

  logic            skid_full;
  logic            pipe_en;
  speck_pkg::out_t last_out;

  speck_ksched #(
    .ROUNDS (ROUNDS)
  ) u_ksched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (ks_busy),
    .rk_o       (rk)
  );

  // Whole pipeline moves together; it only freezes while the skid holds
  // a result, so a stall at the output never drops or duplicates a block.
  assign pipe_en    = !skid_full;
  assign in_ready_o = !skid_full && !ks_busy;

  assign stg_valid[0]         = in_valid_i && in_ready_o;
  assign stg_data[0].cmd      = in_data_i.cmd;
  assign stg_data[0].blk.x    = in_data_i.block_x;
  assign stg_data[0].blk.y    = in_data_i.block_y;

  // Stage g runs encrypt round g, or decrypt round ROUNDS-1-g (keys reversed)
  for (genvar g = 0; g < ROUNDS; g++) begin : g_stage
    speck_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (pipe_en),
      .valid_i   (stg_valid[g]),
      .data_i    (stg_data[g]),
      .enc_key_i (rk[g]),
      .dec_key_i (rk[ROUNDS-1-g]),
      .valid_o   (stg_valid[g+1]),
      .data_o    (stg_data[g+1])
    );
  end

  assign last_out.result_y = stg_data[ROUNDS].blk.y;
  assign last_out.result_x = stg_data[ROUNDS].blk.x;

  speck_oskid u_oskid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid[ROUNDS]),
    .data_i      (last_out),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/speck_ksched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128 key schedule
// Key registers and a one-round-per-cycle expansion into round key registers.
// ----------------------------------------------------------------------------
module speck_ksched #(
  parameter int unsigned ROUNDS = speck_pkg::ROUNDS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [speck_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  speck_pkg::word_t                     cfg_data_i,
  output logic                                 busy_o,
  output logic [ROUNDS-1:0][speck_pkg::WORD_W-1:0] rk_o
);

  localparam int unsigned CNT_W = (ROUNDS > 2) ? $clog2(ROUNDS - 1) : 1;
  localparam logic        EXPAND = (ROUNDS > 1);

  speck_pkg::word_t key0_q, key0_d;
  speck_pkg::word_t key1_q, key1_d;
  speck_pkg::word_t a_q, a_d;
  speck_pkg::word_t b_q, b_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  speck_pkg::pair_t step;

  // schedule round: b plays x, a plays y, the round index is the key
  assign step = speck_pkg::fwd_round('{x: b_q, y: a_q}, speck_pkg::WORD_W'(cnt_q));

  always_comb begin
    key0_d = key0_q;
    key1_d = key1_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        speck_pkg::REG_KEY_WORD0: key0_d = cfg_data_i;
        speck_pkg::REG_KEY_WORD1: key1_d = cfg_data_i;
        default: ;
      endcase
      // restart the expansion from the new key
      a_d    = key0_d;
      b_d    = key1_d;
      cnt_d  = '0;
      busy_d = EXPAND;
    end else if (busy_q) begin
      a_d   = step.y;
      b_d   = step.x;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROUNDS - 2)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      a_q    <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= EXPAND;
    end else begin
      key0_q <= key0_d;
      key1_q <= key1_d;
      a_q    <= a_d;
      b_q    <= b_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign rk_o[0] = key0_q;
  assign busy_o  = busy_q;

  for (genvar g = 1; g < ROUNDS; g++) begin : g_rk
    speck_pkg::word_t rk_q;
    always_ff @(posedge clk_i) begin
      if (busy_q && !cfg_we_i && (cnt_q == CNT_W'(g - 1))) begin
        rk_q <= step.y;
      end
    end
    assign rk_o[g] = rk_q;
  end

endmodule

FILE: rtl/core/speck_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128 round stage
// One registered encrypt or decrypt round, selected by the request command.
// ----------------------------------------------------------------------------
module speck_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  speck_pkg::stage_t data_i,
  input  speck_pkg::word_t  enc_key_i,
  input  speck_pkg::word_t  dec_key_i,
  output logic              valid_o,
  output speck_pkg::stage_t data_o
);

  logic              valid_q;
  speck_pkg::stage_t data_q, data_d;

  always_comb begin
    data_d.cmd = data_i.cmd;
    if (data_i.cmd == speck_pkg::CMD_DECRYPT) begin
      data_d.blk = speck_pkg::inv_round(data_i.blk, dec_key_i);
    end else begin
      data_d.blk = speck_pkg::fwd_round(data_i.blk, enc_key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/speck_oskid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128 output skid
// Holds one result when the consumer stalls; freezes the pipeline while full.
// ----------------------------------------------------------------------------
module speck_oskid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  speck_pkg::out_t data_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output speck_pkg::out_t out_data_o
);

  logic            skid_valid_q, skid_valid_d;
  speck_pkg::out_t skid_q;

  always_comb begin
    if (skid_valid_q) begin
      skid_valid_d = !out_ready_i;
    end else begin
      skid_valid_d = valid_i && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q && valid_i) begin
      skid_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = skid_valid_q || valid_i;
  assign out_data_o  = skid_valid_q ? skid_q : data_i;

endmodule

FILE: rtl/core/speck_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128 port checker
// Port-level assertions on request/result flow and key schedule stalls.
// ----------------------------------------------------------------------------
`include "speck128_block_cipher_macros.svh"

module speck_chk #(
  parameter int unsigned ROUNDS = speck_pkg::ROUNDS_DEF
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_we_i,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input speck_pkg::out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(ROUNDS + 3);

  logic [CNT_W-1:0] inflight_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  `SPECK_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")
  `SPECK_ASSERT(a_no_phantom, out_valid_o |-> inflight_q != '0, "result without a pending request")
  `SPECK_ASSERT(a_bounded, inflight_q <= CNT_W'(ROUNDS + 1), "more requests in flight than storage")
  `SPECK_ASSERT(a_key_stall, (ROUNDS > 1) && cfg_we_i |=> !in_ready_o, "request taken during key expansion")

endmodule

bind speck128_block_cipher speck_chk #(
  .ROUNDS (ROUNDS)
) u_speck_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128/128 cipher testbench
// Sends encrypt and decrypt requests under several key settings. Each result
// is compared with a cipher computed inside the bench. Idle cycles fall at
// random on both channels, and one phase streams with no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
  import speck_pkg::*;

  // Round count passed to the DUT, kept in the 1..MAX_ROUNDS range.
  localparam int NUM_ROUNDS = (ROUNDS_DEF < 1) ? 1 :
                              (ROUNDS_DEF > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS_DEF;
  // Idle cycles in a hundred on either channel.
  localparam int IDLE_PCT    = 31;
  // Cycles with no handshake and no key write before the run is abandoned.
  // Key expansion plus the pipeline depth, with random stalls on top, stays far
  // below this limit, so it leaves a wide margin.
  localparam int STALL_LIMIT = 2000;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_KEY_WORD0;
  word_t                cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_req    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_res;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  speck128_block_cipher #(
    .ROUNDS(NUM_ROUNDS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_res)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  word_t round_key [NUM_ROUNDS];  // key schedule of the current key
  out_t  pending_blocks[$];       // predicted blocks, oldest first
  int    mismatches   = 0;
  int    stall_cycles = 0;
  bit    steady       = 1'b0;     // 1: neither side idles

  // --------------------------------------------------------------------------
  // Cipher prediction
  // --------------------------------------------------------------------------

  // Expands the two key words into the round keys. The schedule reuses the
  // encryption round with the round index as key: b is the x half, a the y.
  function automatic void load_schedule(input word_t k0, input word_t k1);
    word_t a;
    word_t b;
    int    i;
    a = k0;
    b = k1;
    round_key[0] = a;
    for (i = 0; i + 1 < NUM_ROUNDS; i++) begin
      b = ({b[7:0], b[63:8]} + a) ^ word_t'(i);
      a = {a[60:0], a[63:61]} ^ b;
      round_key[i + 1] = a;
    end
  endfunction

  function automatic out_t cipher_block(input in_t req);
    word_t x;
    word_t y;
    out_t  res;
    int    i;
    y = req.block_y;
    x = req.block_x;
    if (req.cmd == CMD_ENCRYPT) begin
      for (i = 0; i < NUM_ROUNDS; i++) begin
        x = ({x[7:0], x[63:8]} + y) ^ round_key[i];
        y = {y[60:0], y[63:61]} ^ x;
      end
    end else begin
      // inverse rounds, last round key first
      for (i = NUM_ROUNDS - 1; i >= 0; i--) begin
        y = y ^ x;
        y = {y[2:0], y[63:3]};
        x = (x ^ round_key[i]) - y;
        x = {x[55:0], x[63:56]};
      end
    end
    res.result_y = y;
    res.result_x = x;
    return res;
  endfunction

  // Mostly uniform words, with a share of corner patterns.
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(63);
      3:       return ~(word_t'(1) << $urandom_range(63));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Writes both key words on consecutive edges, in random order, then
  // rebuilds the bench's schedule. Only called while the DUT is idle.
  task automatic set_key(input word_t k0, input word_t k1);
    bit hi_first;
    hi_first = 1'($urandom_range(1));
    cfg_we   <= 1'b1;
    cfg_idx  <= hi_first ? REG_KEY_WORD1 : REG_KEY_WORD0;
    cfg_data <= hi_first ? k1 : k0;
    @(posedge clk);
    cfg_idx  <= hi_first ? REG_KEY_WORD0 : REG_KEY_WORD1;
    cfg_data <= hi_first ? k0 : k1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    load_schedule(k0, k1);
  endtask

  // Sends one request. Valid is left high after acceptance so that
  // back-to-back requests keep it up; an idle cycle in the next call or the drain lowers it.
  task automatic send_block(input in_t req);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_blocks.push_back(cipher_block(req));
  endtask

  task automatic send_words(input logic cmd, input word_t y, input word_t x);
    in_t req;
    req.cmd     = cmd;
    req.block_y = y;
    req.block_x = x;
    send_block(req);
  endtask

  // Lowers valid and waits until every predicted block has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_blocks.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Key registers as left by reset, no write yet.
  task automatic test_reset_key();
    load_schedule('0, '0);
    send_words(CMD_ENCRYPT, '0, '0);
    send_words(CMD_DECRYPT, '0, '0);
    send_words(CMD_ENCRYPT, '1, '1);
    send_words(CMD_DECRYPT, '1, '1);
    drain_results();
  endtask

  // Published Speck128/128 vector, both directions.
  task automatic test_known_vector();
    set_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_words(CMD_ENCRYPT, 64'h7469206564616d20, 64'h6c61766975716520);
    send_words(CMD_DECRYPT, 64'h7860fedf5c570d18, 64'ha65d985179783265);
    drain_results();
  endtask

  // All-ones key and split keys against extreme block words.
  task automatic test_extreme_keys();
    logic cmd;
    set_key('1, '1);
    for (int c = 0; c < 2; c++) begin
      cmd = c ? CMD_DECRYPT : CMD_ENCRYPT;
      send_words(cmd, '0, '0);
      send_words(cmd, '1, '1);
      send_words(cmd, 64'h8000000000000000, 64'h0000000000000001);
      send_words(cmd, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    end
    drain_results();
    set_key('0, '1);
    send_words(CMD_ENCRYPT, 64'h0000000000000001, 64'h8000000000000000);
    send_words(CMD_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain_results();
    set_key('1, '0);
    send_words(CMD_ENCRYPT, '1, '0);
    send_words(CMD_DECRYPT, '0, '1);
    drain_results();
  endtask

  // Random keys per phase. About a quarter of the requests decrypt the
  // previous ciphertext, so round trips come through with live keys.
  task automatic test_random_traffic(input int phases, input int per_phase);
    in_t  req;
    out_t last_cipher;
    bit   have_cipher;
    for (int p = 0; p < phases; p++) begin
      set_key(rand_word(), rand_word());
      have_cipher = 1'b0;
      for (int n = 0; n < per_phase; n++) begin
        if (have_cipher && $urandom_range(3) == 0) begin
          req.cmd     = CMD_DECRYPT;
          req.block_y = last_cipher.result_y;
          req.block_x = last_cipher.result_x;
        end else begin
          req.cmd     = $urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT;
          req.block_y = rand_word();
          req.block_x = rand_word();
        end
        if (req.cmd == CMD_ENCRYPT) begin
          last_cipher = cipher_block(req);
          have_cipher = 1'b1;
        end
        send_block(req);
      end
      drain_results();
    end
  endtask

  // Full-rate stream: no idle cycles on either side.
  task automatic test_full_rate(input int count);
    set_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
    steady = 1'b1;
    for (int n = 0; n < count; n++)
      send_words($urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT, rand_word(), rand_word());
    drain_results();
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure, then compare against the oldest entry
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: y=%h x=%h",
                                  out_res.result_y, out_res.result_x));
      end else begin
        want = pending_blocks.pop_front();
        if (out_res.result_y !== want.result_y)
          report_mismatch($sformatf("result_y %h, predicted %h",
                                    out_res.result_y, want.result_y));
        if (out_res.result_x !== want.result_x)
          report_mismatch($sformatf("result_x %h, predicted %h",
                                    out_res.result_x, want.result_x));
      end
    end
  end

  // Watchdog: any handshake or key write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_key();
    test_known_vector();
    test_extreme_keys();
    test_random_traffic(7, 130);
    test_full_rate(300);

    // let any stray result surface before closing
    repeat (NUM_ROUNDS + 8) @(posedge clk);
    if (pending_blocks.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_blocks.size()));

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
